// ----- hdl/plucked_string_synth_macros.svh -----
// ----------------------------------------------------------------------------
// Plucked string synth assertion macros
// Shared assertion forms for the port checker.
// ----------------------------------------------------------------------------
`ifndef PLUCKED_STRING_SYNTH_MACROS_SVH
`define PLUCKED_STRING_SYNTH_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define PSS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/pss_pkg.sv -----
// ----------------------------------------------------------------------------
// Plucked string synth package
// Constants, register codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package pss_pkg;

    // Default sizes.
    localparam int VOICES_DEF     = 10;
    localparam int MAX_LENGTH_DEF = 1024;

    // Configuration register map.
    localparam logic REG_NOISE_SEED = 1'b0;
    localparam logic [15:0] SEED_RESET = 16'd44257;

    // Noise generator constants.
    localparam logic [15:0] LFSR_TAPS  = 16'hB400;
    localparam logic [16:0] MOD_RECIP  = 17'd67076;   // ceil(2^27 / 2001)
    localparam logic [10:0] MOD_DIV    = 11'd2001;
    localparam logic [23:0] DIV_RECIP  = 24'd8589935; // ceil(2^30 / 125)
    localparam logic [22:0] NOISE_BIAS = 23'd125;
    localparam logic [16:0] NOISE_OFS  = 17'd16384;

    // Output mapping constants.
    localparam logic [34:0] ROUND_HALF = 35'd65536;
    localparam logic [31:0] CUBE_K     = 32'd3221225472; // 3 * 2^30
    localparam logic [6:0]  CLIP_FULL  = 7'd120;
    localparam logic [7:0]  DAC_MID    = 8'd128;
    localparam logic [15:0] SAT_LIMIT  = 16'd32768;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic pl_sel;
        logic nz_step;
        logic nz_mul1;
        logic nz_mod;
        logic nz_mul2;
        logic nz_wr;
        logic sm_p0;
        logic sm_p1;
        logic sm_p2;
        logic sm_rd;
        logic sm_wr;
        logic pl_fin;
        logic tk_voice;
        logic tk_skip;
        logic tk_a;
        logic tk_b;
        logic tk_wr;
        logic tk_sq;
        logic tk_cub;
        logic tk_out;
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic is_pluck;
        logic active;
        logic last_voice;
        logic last_idx;
        logic last_pass;
        logic no_passes;
        logic out_free;
    } t_status;

endpackage

// ----- hdl/pss_ctrl.sv -----
// ----------------------------------------------------------------------------
// Plucked string synth controller
// Sequences pluck and tick transactions over the datapath.
// ----------------------------------------------------------------------------
module pss_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  pss_pkg::t_status  i_status,
    output pss_pkg::t_cmd     o_cmd
);
    import pss_pkg::*;

    localparam logic [4:0] S_IDLE    = 5'd0;
    localparam logic [4:0] S_DISP    = 5'd1;
    localparam logic [4:0] S_PL_SEL  = 5'd2;
    localparam logic [4:0] S_NZ_STEP = 5'd3;
    localparam logic [4:0] S_NZ_MUL1 = 5'd4;
    localparam logic [4:0] S_NZ_MOD  = 5'd5;
    localparam logic [4:0] S_NZ_MUL2 = 5'd6;
    localparam logic [4:0] S_NZ_WR   = 5'd7;
    localparam logic [4:0] S_SM_P0   = 5'd8;
    localparam logic [4:0] S_SM_P1   = 5'd9;
    localparam logic [4:0] S_SM_P2   = 5'd10;
    localparam logic [4:0] S_SM_RD   = 5'd11;
    localparam logic [4:0] S_SM_WR   = 5'd12;
    localparam logic [4:0] S_PL_FIN  = 5'd13;
    localparam logic [4:0] S_TK_VOX  = 5'd14;
    localparam logic [4:0] S_TK_A    = 5'd15;
    localparam logic [4:0] S_TK_B    = 5'd16;
    localparam logic [4:0] S_TK_WR   = 5'd17;
    localparam logic [4:0] S_TK_SQ   = 5'd18;
    localparam logic [4:0] S_TK_CUB  = 5'd19;
    localparam logic [4:0] S_TK_OUT  = 5'd20;

    logic [4:0] r_state;
    logic [4:0] n_state;

    // New transactions are taken only when idle.
    assign o_in_stall = (r_state != S_IDLE);

    // Next state and command decode.
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DISP;
                end
            end
            S_DISP: begin
                n_state = i_status.is_pluck ? S_PL_SEL : S_TK_VOX;
            end
            S_PL_SEL: begin
                o_cmd.pl_sel = 1'b1;
                n_state      = S_NZ_STEP;
            end
            S_NZ_STEP: begin
                o_cmd.nz_step = 1'b1;
                n_state       = S_NZ_MUL1;
            end
            S_NZ_MUL1: begin
                o_cmd.nz_mul1 = 1'b1;
                n_state       = S_NZ_MOD;
            end
            S_NZ_MOD: begin
                o_cmd.nz_mod = 1'b1;
                n_state      = S_NZ_MUL2;
            end
            S_NZ_MUL2: begin
                o_cmd.nz_mul2 = 1'b1;
                n_state       = S_NZ_WR;
            end
            S_NZ_WR: begin
                o_cmd.nz_wr = 1'b1;
                if (!i_status.last_idx) begin
                    n_state = S_NZ_STEP;
                end else if (i_status.no_passes) begin
                    n_state = S_PL_FIN;
                end else begin
                    n_state = S_SM_P0;
                end
            end
            S_SM_P0: begin
                o_cmd.sm_p0 = 1'b1;
                n_state     = S_SM_P1;
            end
            S_SM_P1: begin
                o_cmd.sm_p1 = 1'b1;
                n_state     = S_SM_P2;
            end
            S_SM_P2: begin
                o_cmd.sm_p2 = 1'b1;
                n_state     = S_SM_RD;
            end
            S_SM_RD: begin
                o_cmd.sm_rd = 1'b1;
                n_state     = S_SM_WR;
            end
            S_SM_WR: begin
                o_cmd.sm_wr = 1'b1;
                if (!i_status.last_idx) begin
                    n_state = S_SM_RD;
                end else if (i_status.last_pass) begin
                    n_state = S_PL_FIN;
                end else begin
                    n_state = S_SM_P0;
                end
            end
            S_PL_FIN: begin
                o_cmd.pl_fin = 1'b1;
                n_state      = S_IDLE;
            end
            S_TK_VOX: begin
                if (i_status.active) begin
                    o_cmd.tk_voice = 1'b1;
                    n_state        = S_TK_A;
                end else if (i_status.last_voice) begin
                    n_state = S_TK_SQ;
                end else begin
                    o_cmd.tk_skip = 1'b1;
                end
            end
            S_TK_A: begin
                o_cmd.tk_a = 1'b1;
                n_state    = S_TK_B;
            end
            S_TK_B: begin
                o_cmd.tk_b = 1'b1;
                n_state    = S_TK_WR;
            end
            S_TK_WR: begin
                o_cmd.tk_wr = 1'b1;
                n_state     = i_status.last_voice ? S_TK_SQ : S_TK_VOX;
            end
            S_TK_SQ: begin
                o_cmd.tk_sq = 1'b1;
                n_state     = S_TK_CUB;
            end
            S_TK_CUB: begin
                o_cmd.tk_cub = 1'b1;
                n_state      = S_TK_OUT;
            end
            S_TK_OUT: begin
                if (i_status.out_free) begin
                    o_cmd.tk_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- hdl/pss_dp.sv -----
// ----------------------------------------------------------------------------
// Plucked string synth datapath
// Delay line memory, voice registers, noise generator and output mapping.
// ----------------------------------------------------------------------------
module pss_dp #(
    parameter int VOICES     = pss_pkg::VOICES_DEF,
    parameter int MAX_LENGTH = pss_pkg::MAX_LENGTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  pss_pkg::t_cmd     i_cmd,
    output pss_pkg::t_status  o_status,
    input  logic              i_mode,
    input  logic [10:0]       i_period_len,
    input  logic [15:0]       i_decay_q,
    input  logic [2:0]        i_smooth_passes,
    input  logic [19:0]       i_life_samples,
    input  logic              i_cfg_we,
    input  logic [15:0]       i_cfg_data,
    output logic [15:0]       o_seed,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [7:0]        o_dac_value
);
    import pss_pkg::*;

    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int LW = $clog2(MAX_LENGTH + 1);
    localparam int IW = $clog2(MAX_LENGTH);
    localparam int AW = $clog2(VOICES * MAX_LENGTH);
    localparam int MW = 17 + VW;
    localparam int DEPTH = VOICES * MAX_LENGTH;

    // Latched transaction fields.
    logic        r_mode;
    logic [10:0] r_period;
    logic [15:0] r_decay_in;
    logic [2:0]  r_passes;
    logic [19:0] r_life_in;

    // Per-voice state.
    logic [LW-1:0] r_len    [VOICES];
    logic [IW-1:0] r_pos    [VOICES];
    logic [15:0]   r_vdecay [VOICES];
    logic [19:0]   r_life   [VOICES];
    logic [VOICES-1:0] r_active;
    logic [VW-1:0] r_steal;

    // Work registers.
    logic [15:0]   r_seed;
    logic [15:0]   r_lfsr;
    logic [VW-1:0] r_v;
    logic [IW-1:0] r_idx;
    logic [LW-1:0] r_cur_len;
    logic [2:0]    r_pass;
    logic [45:0]   r_nz_prod;
    logic [10:0]   r_rem;
    logic signed [15:0] r_prev;
    logic signed [15:0] r_cur;
    logic signed [15:0] r_a;
    logic signed [33:0] r_tk_prod;
    logic signed [MW-1:0] r_mix;
    logic          r_sat;
    logic          r_neg;
    logic [15:0]   r_abs;
    logic [31:0]   r_sq;
    logic [47:0]   r_cube;
    logic          r_out_valid;
    logic [7:0]    r_dac;

    // Delay line memory.
    logic signed [15:0] r_mem [DEPTH];
    logic signed [15:0] r_rd_data;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic signed [15:0] wr_data;
    logic [IW-1:0] rd_idx;
    logic [AW-1:0] rd_addr;
    logic [IW-1:0] idx_next;
    logic [IW-1:0] len_last;
    logic          free_found;
    logic [VW-1:0] free_v;
    logic [LW-1:0] clamp_len;
    logic [15:0]   lfsr_next;
    logic [5:0]    mod_q;
    logic [21:0]   nz_x;
    logic signed [16:0] nz_sample;
    logic signed [18:0] sm_sum;
    logic signed [16:0] tk_ab;
    logic signed [34:0] tk_round;
    logic [MW-1:0] mix_abs;
    logic [53:0]   cube_scaled;
    logic [6:0]    clip_t;

    function automatic logic [AW-1:0] line_addr(input logic [VW-1:0] v,
                                                 input logic [IW-1:0] idx);
        line_addr = AW'(v) * AW'(MAX_LENGTH) + AW'(idx);
    endfunction

    // Circular successor of the current index.
    assign idx_next = ((LW'(r_idx) + LW'(1)) >= r_cur_len) ? '0 : r_idx + IW'(1);
    assign len_last = IW'(r_cur_len - LW'(1));

    // Lowest-numbered free voice.
    always_comb begin
        free_found = 1'b0;
        free_v     = '0;
        for (int i = VOICES - 1; i >= 0; i--) begin
            if (!r_active[i]) begin
                free_found = 1'b1;
                free_v     = VW'(i);
            end
        end
    end

    // Delay line length clamp.
    always_comb begin
        if (int'(r_period) > MAX_LENGTH) begin
            clamp_len = LW'(MAX_LENGTH);
        end else if (r_period < 11'd2) begin
            clamp_len = LW'(2);
        end else begin
            clamp_len = LW'(r_period);
        end
    end

    // Noise arithmetic.
    assign lfsr_next = (r_lfsr >> 1) ^ (r_lfsr[0] ? LFSR_TAPS : 16'd0);
    assign mod_q     = r_nz_prod[32:27];
    assign nz_x      = 22'(({12'd0, r_rem} * 23'd4096 + NOISE_BIAS) >> 1);
    assign nz_sample = $signed({1'b0, r_nz_prod[45:30]}) - $signed(NOISE_OFS);

    // Smoothing and loop filter arithmetic.
    assign sm_sum   = 19'(r_prev) + (19'(r_cur) <<< 1) + 19'(r_rd_data) + 19'sd2;
    assign tk_ab    = 17'(r_a) + 17'(r_rd_data);
    assign tk_round = 35'(r_tk_prod) + $signed(ROUND_HALF);

    // Soft clip arithmetic.
    assign mix_abs     = r_mix[MW-1] ? MW'(-r_mix) : MW'(r_mix);
    assign cube_scaled = 54'(r_cube) * 54'd60;
    assign clip_t      = r_sat ? CLIP_FULL : cube_scaled[51:45];

    // Memory port selection.
    always_comb begin
        rd_idx = r_idx;
        if (i_cmd.sm_p0) begin
            rd_idx = len_last;
        end else if (i_cmd.sm_p1) begin
            rd_idx = '0;
        end else if (i_cmd.sm_rd || i_cmd.tk_a) begin
            rd_idx = idx_next;
        end else if (i_cmd.tk_voice) begin
            rd_idx = r_pos[r_v];
        end
        rd_addr = line_addr(r_v, rd_idx);
        wr_en   = i_cmd.nz_wr || i_cmd.sm_wr || i_cmd.tk_wr;
        wr_addr = line_addr(r_v, r_idx);
        if (i_cmd.nz_wr) begin
            wr_data = 16'(nz_sample);
        end else if (i_cmd.sm_wr) begin
            wr_data = 16'(sm_sum >>> 2);
        end else begin
            wr_data = 16'(tk_round >>> 17);
        end
    end

    // Memory with registered read.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    // Control state: voice flags and per-voice registers, steal pointer, seed, LFSR, output valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_steal     <= '0;
            r_seed      <= SEED_RESET;
            r_lfsr      <= SEED_RESET;
            r_out_valid <= 1'b0;
            for (int i = 0; i < VOICES; i++) begin
                r_len[i]    <= '0;
                r_pos[i]    <= '0;
                r_vdecay[i] <= '0;
                r_life[i]   <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_seed <= i_cfg_data;
                r_lfsr <= i_cfg_data;
            end
            if (i_cmd.nz_step) begin
                r_lfsr <= lfsr_next;
            end
            if (i_cmd.pl_sel && !free_found) begin
                r_steal <= (r_steal == VW'(VOICES - 1)) ? '0 : r_steal + VW'(1);
            end
            if (i_cmd.pl_sel) begin
                r_len[free_found ? free_v : r_steal] <= clamp_len;
            end
            if (i_cmd.pl_fin) begin
                r_pos[r_v]    <= '0;
                r_vdecay[r_v] <= r_decay_in;
                r_life[r_v]   <= r_life_in;
                r_active[r_v] <= 1'b1;
            end
            if (i_cmd.tk_wr) begin
                r_pos[r_v] <= idx_next;
                if (r_life[r_v] != 20'd0) begin
                    r_life[r_v] <= r_life[r_v] - 20'd1;
                end else begin
                    r_active[r_v] <= 1'b0;
                end
            end
            if (i_cmd.tk_out) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload and work registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode     <= i_mode;
            r_period   <= i_period_len;
            r_decay_in <= i_decay_q;
            r_passes   <= i_smooth_passes;
            r_life_in  <= i_life_samples;
            r_v        <= '0;
            r_mix      <= '0;
        end
        if (i_cmd.pl_sel) begin
            r_v       <= free_found ? free_v : r_steal;
            r_cur_len <= clamp_len;
            r_idx     <= '0;
            r_pass    <= '0;
        end
        if (i_cmd.nz_mul1) begin
            r_nz_prod <= 46'(r_lfsr * MOD_RECIP);
        end
        if (i_cmd.nz_mod) begin
            r_rem <= 11'(r_lfsr - 16'(mod_q * MOD_DIV));
        end
        if (i_cmd.nz_mul2) begin
            r_nz_prod <= 46'(nz_x * DIV_RECIP);
        end
        if (i_cmd.nz_wr) begin
            r_idx <= (r_idx == len_last) ? '0 : r_idx + IW'(1);
        end
        if (i_cmd.sm_p1) begin
            r_prev <= r_rd_data;
            r_idx  <= '0;
        end
        if (i_cmd.sm_p2) begin
            r_cur <= r_rd_data;
        end
        if (i_cmd.sm_wr) begin
            r_prev <= r_cur;
            r_cur  <= r_rd_data;
            if (r_idx == len_last) begin
                r_idx  <= '0;
                r_pass <= r_pass + 3'd1;
            end else begin
                r_idx <= r_idx + IW'(1);
            end
        end
        if (i_cmd.tk_voice) begin
            r_cur_len <= r_len[r_v];
            r_idx     <= r_pos[r_v];
        end
        if (i_cmd.tk_a) begin
            r_a <= r_rd_data;
        end
        if (i_cmd.tk_b) begin
            r_tk_prod <= tk_ab * $signed({1'b0, r_vdecay[r_v]});
        end
        if (i_cmd.tk_wr) begin
            r_mix <= r_mix + MW'(r_a);
        end
        if (i_cmd.tk_skip || i_cmd.tk_wr) begin
            r_v <= (r_v == VW'(VOICES - 1)) ? '0 : r_v + VW'(1);
        end
        if (i_cmd.tk_sq) begin
            r_neg <= r_mix[MW-1];
            r_sat <= mix_abs > MW'(SAT_LIMIT);
            r_abs <= mix_abs[15:0];
            r_sq  <= mix_abs[15:0] * mix_abs[15:0];
        end
        if (i_cmd.tk_cub) begin
            r_cube <= r_abs * (CUBE_K - r_sq);
        end
        if (i_cmd.tk_out) begin
            r_dac <= r_neg ? DAC_MID - 8'(clip_t) : DAC_MID + 8'(clip_t);
        end
    end

    // Status to the controller.
    assign o_status.is_pluck   = r_mode;
    assign o_status.active     = r_active[r_v];
    assign o_status.last_voice = (r_v == VW'(VOICES - 1));
    assign o_status.last_idx   = (r_idx == len_last);
    assign o_status.last_pass  = ({1'b0, r_pass} + 4'd1) == {1'b0, r_passes};
    assign o_status.no_passes  = (r_passes == 3'd0);
    assign o_status.out_free   = !r_out_valid || !i_out_stall;

    assign o_seed      = r_seed;
    assign o_out_valid = r_out_valid;
    assign o_dac_value = r_dac;

endmodule

// ----- hdl/plucked_string_synth.sv -----
// ----------------------------------------------------------------------------
// Plucked string synth
// Polyphonic plucked-string voice engine with an 8-bit DAC output.
//
//   Channel   Direction  Handshake             Payload
//   input     in         i_in_valid/o_in_stall mode, period, decay, passes, life
//   output    out        o_out_valid/i_out_stall dac_value
//   config    in         APB-style write/read  noise_seed at byte address 0
//
// A tick visits every voice in turn, making two reads for each active voice
// on the single delay line read port and skipping each idle voice.
// A pluck fills the line through the noise divider steps, then runs each
// smoothing pass over the read port.
// Reset is synchronous; all voices come out idle and the seed is reloaded.
// A result waits in the output register while the sink stalls.
// ----------------------------------------------------------------------------
module plucked_string_synth #(
    parameter int VOICES     = pss_pkg::VOICES_DEF,
    parameter int MAX_LENGTH = pss_pkg::MAX_LENGTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_mode,
    input  logic [10:0] i_period_len,
    input  logic [15:0] i_decay_q,
    input  logic [2:0]  i_smooth_passes,
    input  logic [19:0] i_life_samples,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_dac_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import pss_pkg::*;

    t_cmd        cmd;
    t_status     status;
    logic        cfg_we;
    logic [15:0] seed;

    // Register access decode.
    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && (paddr[2] == REG_NOISE_SEED);
    assign prdata = (paddr[2] == REG_NOISE_SEED) ? {16'd0, seed} : 32'd0;

    pss_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    pss_dp #(
        .VOICES     (VOICES),
        .MAX_LENGTH (MAX_LENGTH)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_mode          (i_mode),
        .i_period_len    (i_period_len),
        .i_decay_q       (i_decay_q),
        .i_smooth_passes (i_smooth_passes),
        .i_life_samples  (i_life_samples),
        .i_cfg_we        (cfg_we),
        .i_cfg_data      (pwdata[15:0]),
        .o_seed          (seed),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_dac_value     (o_dac_value)
    );

endmodule

// ----- hdl/pss_checker.sv -----
// ----------------------------------------------------------------------------
// Plucked string synth port checker
// Watches the top-level ports over time and binds to the top level.
// ----------------------------------------------------------------------------
`include "plucked_string_synth_macros.svh"

module pss_sva (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        o_in_stall,
    input logic        o_out_valid,
    input logic        i_out_stall,
    input logic [7:0]  o_dac_value
);

    // An accepted transaction keeps the block busy in the next cycle.
    `PSS_ASSERT_NEXT(a_busy_after_accept, i_in_valid && !o_in_stall, o_in_stall, "not busy after accept")

    // A stalled result holds its value.
    `PSS_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(o_dac_value), "stalled result changed")

    // The soft clip keeps the DAC code within its swing.
    `PSS_ASSERT_NOW(a_dac_range, o_out_valid, o_dac_value >= 8'd8 && o_dac_value <= 8'd248, "DAC value out of range")

endmodule

bind plucked_string_synth pss_sva u_pss_checker (.*);

// ----- test/pss_checker.sv -----
// ----------------------------------------------------------------------------
// Plucked string synth checker
// Watches the input and output channels and the configuration port, keeps its
// own copy of every voice, predicts each DAC value and compares it.
// ----------------------------------------------------------------------------
module pss_checker #(
    parameter int VOICES     = 10,
    parameter int MAX_LENGTH = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_mode,
    input  logic [10:0] i_period_len,
    input  logic [15:0] i_decay_q,
    input  logic [2:0]  i_smooth_passes,
    input  logic [19:0] i_life_samples,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [7:0]  i_dac_value,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    logic signed [15:0] line_mem [VOICES][MAX_LENGTH];
    int unsigned        line_len [VOICES];
    int unsigned        line_pos [VOICES];
    bit                 voice_on [VOICES];
    logic [15:0]        voice_gain [VOICES];
    logic [19:0]        voice_life [VOICES];
    int unsigned        steal_idx;
    logic [15:0]        lfsr;
    logic [7:0]         dac_queue [$];
    int                 fails;

    assign o_fail_count = fails;
    assign o_pending    = dac_queue.size();

    // Floor division by a power of two on a signed value.
    function automatic longint floor_div(input longint x, input int n);
        return x >>> n;
    endfunction

    function automatic logic signed [15:0] noise_sample();
        logic        lsb;
        int unsigned r;
        lsb  = lfsr[0];
        lfsr = lfsr >> 1;
        if (lsb) lfsr = lfsr ^ LFSR_TAPS;
        r = lfsr % 2001;
        return 16'((r * 16384 + 500) / 1000) - 16'sd16384;
    endfunction

    // Pluck: choose a voice, excite it with noise and smooth the line.
    task automatic pluck_voice(input logic [10:0] per, input logic [15:0] dec,
                               input logic [2:0] passes, input logic [19:0] life);
        int          v;
        int unsigned len;
        longint      prev, cur, nxt;
        v = -1;
        for (int i = 0; i < VOICES; i++)
            if (!voice_on[i] && v < 0) v = i;
        if (v < 0) begin
            v = steal_idx % VOICES;
            steal_idx = (v + 1) % VOICES;
        end
        len = per;
        if (len > MAX_LENGTH) len = MAX_LENGTH;
        if (len < 2) len = 2;
        line_len[v] = len;
        for (int i = 0; i < len; i++) line_mem[v][i] = noise_sample();
        for (int p = 0; p < passes; p++) begin
            prev = line_mem[v][len-1];
            for (int i = 0; i < len; i++) begin
                cur  = line_mem[v][i];
                nxt  = line_mem[v][(i + 1 >= len) ? 0 : i + 1];
                line_mem[v][i] = 16'(floor_div(prev + 2 * cur + nxt + 2, 2));
                prev = cur;
            end
        end
        line_pos[v]   = 0;
        voice_gain[v] = dec;
        voice_on[v]   = 1'b1;
        voice_life[v] = life;
    endtask

    // Tick: advance each active voice, mix and soft clip.
    function automatic logic [7:0] tick_dac();
        longint      mix, a, b, s, t, num;
        int unsigned len, pos, n;
        mix = 0;
        for (int v = 0; v < VOICES; v++) begin
            if (voice_on[v]) begin
                len = line_len[v];
                pos = line_pos[v];
                if (pos >= len) pos = 0;
                n = (pos + 1 >= len) ? 0 : pos + 1;
                a = line_mem[v][pos];
                b = line_mem[v][n];
                line_mem[v][pos] =
                    16'(floor_div((a + b) * longint'(voice_gain[v]) + 65536, 17));
                line_pos[v] = n;
                mix += a;
                if (voice_life[v] != 0) voice_life[v]--;
                else voice_on[v] = 1'b0;
            end
        end
        s = (mix < 0) ? -mix : mix;
        if (s > 32768) t = 120;
        else begin
            num = 180 * s * (longint'(1) << 30) - 60 * s * s * s;
            t = longint'(longint'(unsigned'(num)) >> 45);
            t = num >>> 45;
        end
        return 8'((mix < 0) ? 128 - t : 128 + t);
    endfunction

    task automatic report_mismatch(input string what);
        $display("mismatch at %0t: %s", $realtime, what);
        fails++;
    endtask

    // Channel monitor: reset, register writes, input and output transactions.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int v = 0; v < VOICES; v++) begin
                line_len[v] = 0; line_pos[v] = 0; voice_on[v] = 0;
                voice_gain[v] = 0; voice_life[v] = 0;
            end
            steal_idx = 0;
            lfsr      = SEED_RESET;
            dac_queue.delete();
        end else begin
            if (psel && penable && pwrite && pready && paddr == 3'(REG_NOISE_SEED))
                lfsr = pwdata[15:0];
            if (i_in_valid && !i_in_stall) begin
                if (i_mode) pluck_voice(i_period_len, i_decay_q, i_smooth_passes,
                                        i_life_samples);
                else dac_queue.push_back(tick_dac());
            end
            if (i_out_valid && !i_out_stall) begin
                if (dac_queue.size() == 0)
                    report_mismatch($sformatf("unexpected dac_value %0d", i_dac_value));
                else if (dac_queue[0] !== i_dac_value) begin
                    report_mismatch($sformatf("dac_value %0d, expected %0d",
                                              i_dac_value, dac_queue[0]));
                    void'(dac_queue.pop_front());
                end else void'(dac_queue.pop_front());
            end
        end
    end

    initial fails = 0;
endmodule

// ----- test/tb_plucked_string_synth.sv -----
// ----------------------------------------------------------------------------
// Plucked string synth testbench
// Drives plucks and ticks with random idling and stalls, writes the noise
// seed between phases, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb_plucked_string_synth;
    timeunit 1ns;
    timeprecision 1ps;

    import pss_pkg::*;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_PLUCK = 1'b1;
    localparam int   CYCLE_LIMIT = 3_000_000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic        i_mode = MODE_TICK;
    logic [10:0] i_period_len = '0;
    logic [15:0] i_decay_q = '0;
    logic [2:0]  i_smooth_passes = '0;
    logic [19:0] i_life_samples = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [7:0]  o_dac_value;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    int          fail_count, pending;
    int          cycles = 0;
    bit          calm = 1'b0;
    bit          hold_sink = 1'b0;

    always #1 i_clk = ~i_clk;

    plucked_string_synth u_top (.*);

    pss_checker u_chk (
        .i_clk, .i_rst_n, .i_in_valid, .i_in_stall(o_in_stall), .i_mode,
        .i_period_len, .i_decay_q, .i_smooth_passes, .i_life_samples,
        .i_out_valid(o_out_valid), .i_out_stall, .i_dac_value(o_dac_value),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending)
    );

    // Sink stalls: random, none when calm, solid during a hold-off.
    always @(posedge i_clk) begin
        i_out_stall <= hold_sink || (!calm && $urandom_range(99) < 36);
    end

    // Watchdog.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Send one transaction, idling beforehand at random. Valid stays high
    // after acceptance until the next idle cycle or the next drain.
    task automatic send(input logic m, input logic [10:0] per, input logic [15:0] dec,
                        input logic [2:0] sp, input logic [19:0] life);
        while (!calm && $urandom_range(99) < 36) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_mode          <= m;
        i_period_len    <= per;
        i_decay_q       <= dec;
        i_smooth_passes <= sp;
        i_life_samples  <= life;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
    endtask

    task automatic tick();
        send(MODE_TICK, 11'($urandom), 16'($urandom), 3'($urandom), 20'($urandom));
    endtask

    // Wait for every expected transaction and a pluck's worth of extra cycles.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (pending != 0) @(posedge i_clk);
        repeat (40000) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [15:0] seed);
        psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
        paddr <= 3'(REG_NOISE_SEED); pwdata <= {16'h0, seed};
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        @(posedge i_clk);
    endtask

    // Random pluck, mostly short lines with a rare full-length one.
    task automatic rand_pluck();
        logic [10:0] per;
        per = ($urandom_range(99) < 3) ? 11'($urandom_range(1024, 2047))
                                       : 11'($urandom_range(0, 64));
        send(MODE_PLUCK, per, 16'($urandom), 3'($urandom),
             ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(0, 60)));
    endtask

    initial begin
        logic [15:0] seeds [4];
        seeds = '{16'd1, 16'hFFFF, 16'h0, 16'h1234};
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: line length extremes, zero life, zero and full decay.
        send(MODE_TICK, 11'd0, 16'd0, 3'd0, 20'd0);
        send(MODE_PLUCK, 11'd0, 16'hFFFF, 3'd0, 20'd0);
        send(MODE_PLUCK, 11'd1, 16'h0000, 3'd7, 20'hFFFFF);
        send(MODE_PLUCK, 11'd2, 16'h8000, 3'd1, 20'd3);
        send(MODE_PLUCK, 11'd1024, 16'hFFFF, 3'd2, 20'd50);
        send(MODE_PLUCK, 11'd2047, 16'hFFFE, 3'd7, 20'd40);
        repeat (4) tick();
        // Fill every voice, then steal several.
        for (int i = 0; i < 14; i++)
            send(MODE_PLUCK, 11'($urandom_range(2, 20)), 16'hFFFF, 3'($urandom),
                 20'hFFFFF);
        repeat (6) tick();
        drain();

        // Random phases with a different seed each, seed extremes among them.
        for (int ph = 0; ph < 4; ph++) begin
            write_seed(seeds[ph]);
            calm = (ph == 1);
            for (int n = 0; n < 330; n++) begin
                if ($urandom_range(99) < 15) rand_pluck();
                else tick();
                if (ph == 2 && n == 100) begin
                    // Long sink hold-off while the source keeps offering.
                    fork
                        begin
                            hold_sink = 1'b1;
                            repeat (300) @(posedge i_clk);
                            hold_sink = 1'b0;
                        end
                        repeat (20) tick();
                    join
                end
            end
            drain();
        end

        if (fail_count == 0) $display("*** PASSED ***");
        else $display("*** FAILED ***");
        $finish;
    end
endmodule
